@@ hw/rtl/sps_pkg.sv @@
// Shared constants, codes and the arctangent table for the sphere
// point-to-surface parameter block. No dependencies.
package sps_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int ANGLE_ITER_DEF  = 16;

	// extra fraction bits kept on the in-plane radius before the polar angle
	localparam int SQRT_EXTRA  = 8;
	localparam int QUEUE_DEPTH = 4;

	// CORDIC: operands are normalized so the larger one has its top bit here
	localparam int CORDIC_MSB = 40;
	localparam int CORDIC_XW  = 45;
	localparam int ZACC_W     = 34;
	localparam int ANGLE_W    = 33;

	localparam logic [ANGLE_W-1:0] TURN_QUARTER = 33'h0_4000_0000;
	localparam logic [ANGLE_W-1:0] TURN_HALF    = 33'h0_8000_0000;
	localparam logic [ANGLE_W-1:0] TURN_FULL    = 33'h1_0000_0000;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE     = 3'd4;

	localparam int POLE_W = 2;
	localparam logic [POLE_W-1:0] POLE_X = 2'd0;
	localparam logic [POLE_W-1:0] POLE_Y = 2'd1;
	localparam logic [POLE_W-1:0] POLE_Z = 2'd2;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/sps_front.sv @@
// Front end: forms the offset from the centre, applies orientation and pole
// selection, and queues the classified point. Depends on sps_pkg.
module sps_front import sps_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [CW-1:0]  pos_x,
	input  logic signed [CW-1:0]  pos_y,
	input  logic signed [CW-1:0]  pos_z,
	input  logic signed [CW-1:0]  centre_x,
	input  logic signed [CW-1:0]  centre_y,
	input  logic signed [CW-1:0]  centre_z,
	input  logic signed [CW-1:0]  radius,
	input  logic [POLE_W-1:0]     pole,
	output logic                  q_vld,
	output logic [3*CW+3:0]       q_data,
	input  logic                  q_pop
);
	localparam int DW  = CW + 1;
	localparam int EW  = 3 * DW + 1;
	localparam int PTW = $clog2(QUEUE_DEPTH);
	localparam int CTW = $clog2(QUEUE_DEPTH + 1);

	logic signed [DW-1:0] d0, d1, d2, ar, ur, vr, a, u, v;
	logic                 aflip, inv, cen, push;
	logic [EW-1:0]        mem_q [0:QUEUE_DEPTH-1];
	logic [PTW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CTW-1:0]       cnt_q;

	always_comb begin
		d0 = DW'(pos_x) - DW'(centre_x);
		d1 = DW'(pos_y) - DW'(centre_y);
		d2 = DW'(pos_z) - DW'(centre_z);
		inv = radius[CW-1];
		case (pole)
			POLE_X: begin
				ar = d0; ur = d1; vr = d2; aflip = 1'b1;
			end
			POLE_Y: begin
				ar = d1; ur = d0; vr = d2; aflip = 1'b0;
			end
			default: begin
				ar = d2; ur = d0; vr = d1; aflip = 1'b1;
			end
		endcase
		// polar axis points away from the pole on X and Z
		a   = (inv ^ aflip) ? -ar : ar;
		u   = inv ? -ur : ur;
		v   = inv ? -vr : vr;
		cen = (d0 == '0) && (d1 == '0) && (d2 == '0);
	end

	assign in_stall = (cnt_q == CTW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_vld    = (cnt_q != '0);
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= {cen, a, u, v};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CTW'(push) - CTW'(q_pop);
		end
	end

endmodule

@@ hw/rtl/sps_sqrt.sv @@
// Two-lane pipelined integer square root, one root bit per stage, rounded
// to nearest in a final stage. Carries a side payload. Depends on sps_pkg.
module sps_sqrt import sps_pkg::*; #(
	parameter int IN_W   = 84,
	parameter int SIDE_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [1:0][IN_W-1:0]      in_val,
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_vld,
	output logic [1:0][IN_W/2-1:0]    out_root,
	output logic [SIDE_W-1:0]         out_side
);
	localparam int RW = IN_W / 2;
	localparam int NS = RW;

	logic [IN_W-1:0]   val_s  [0:1][1:NS];
	logic [RW-1:0]     root_s [0:1][1:NS];
	logic [RW+1:0]     rem_s  [0:1][1:NS];
	logic [RW-1:0]     root_q [0:1];
	logic [SIDE_W-1:0] side_q [0:NS];
	logic [NS:0]       vld_q;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 0; k < NS; k++) begin : g_stage
			logic [IN_W-1:0] v_in;
			logic [RW-1:0]   r_in;
			logic [RW+1:0]   m_in;
			logic [RW+3:0]   cur, trial, diff;
			logic            ge;

			if (k == 0) begin : g_first
				assign v_in = in_val[l];
				assign r_in = '0;
				assign m_in = '0;
			end else begin : g_next
				assign v_in = val_s[l][k];
				assign r_in = root_s[l][k];
				assign m_in = rem_s[l][k];
			end

			assign cur   = {m_in, v_in[IN_W-1 -: 2]};
			assign trial = {2'b00, r_in, 2'b01};
			assign ge    = (cur >= trial);
			assign diff  = cur - trial;

			always_ff @(posedge clk) begin
				if (en) begin
					val_s[l][k+1]  <= v_in << 2;
					root_s[l][k+1] <= {r_in[RW-2:0], ge};
					rem_s[l][k+1]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[l] <= root_s[l][NS] +
					RW'(rem_s[l][NS] > {2'b00, root_s[l][NS]});
			end
		end

		assign out_root[l] = root_q[l];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int j = 1; j <= NS; j++) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-1:0], in_vld};
		end
	end

	assign out_vld  = vld_q[NS];
	assign out_side = side_q[NS];

endmodule

@@ hw/rtl/sps_cordic.sv @@
// Two-lane unrolled CORDIC vectoring: normalize, rotate, then map the
// first-quadrant angle to a full turn from the operand signs. Depends on sps_pkg.
module sps_cordic import sps_pkg::*; #(
	parameter int AW     = 41,
	parameter int ITER   = ANGLE_ITER_DEF,
	parameter int SIDE_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [1:0][AW-1:0]         in_ax,
	input  logic [1:0][AW-1:0]         in_ay,
	input  logic [1:0]                 in_xneg,
	input  logic [1:0]                 in_yneg,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_vld,
	output logic [1:0][ANGLE_W-1:0]    out_angle,
	output logic [SIDE_W-1:0]          out_side
);
	localparam int PW  = $clog2(AW);
	localparam int SHW = $clog2(AW + CORDIC_MSB) + 1;
	localparam int WW  = (AW > CORDIC_XW) ? AW : CORDIC_XW;
	localparam int NST = ITER + 3;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zx;
		logic zy;
	} cflag_t;

	logic [1:0][AW-1:0]          ax_s0, ay_s0;
	logic [1:0][PW-1:0]          pos_s0;
	cflag_t [1:0]                flg_q [0:ITER+1];
	logic signed [CORDIC_XW-1:0] x_s [0:1][0:ITER];
	logic signed [CORDIC_XW-1:0] y_s [0:1][0:ITER];
	logic signed [ZACC_W-1:0]    z_s [0:1][1:ITER];
	logic [ANGLE_W-1:0]          ang_q [0:1];
	logic [SIDE_W-1:0]           side_q [0:NST-1];
	logic [NST-1:0]              vld_q;

	function automatic logic [PW-1:0] msb_pos(input logic [AW-1:0] m);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < AW; i++) begin
			if (m[i]) begin
				p = PW'(i);
			end
		end
		return p;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				ax_s0[l]    <= in_ax[l];
				ay_s0[l]    <= in_ay[l];
				pos_s0[l]   <= msb_pos(in_ax[l] | in_ay[l]);
				flg_q[0][l] <= '{xneg: in_xneg[l], yneg: in_yneg[l],
					zx: (in_ax[l] == '0), zy: (in_ay[l] == '0)};
			end
			for (int j = 1; j <= ITER + 1; j++) begin
				flg_q[j] <= flg_q[j-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [SHW-1:0]     pos_w;
		logic [WW-1:0]      xw, yw;
		logic signed [ZACC_W-1:0] zc;
		logic [ANGLE_W-1:0] th;
		cflag_t             f;

		always_comb begin
			pos_w = SHW'(pos_s0[l]);
			if (pos_w > SHW'(CORDIC_MSB)) begin
				xw = WW'(ax_s0[l]) >> (pos_w - SHW'(CORDIC_MSB));
				yw = WW'(ay_s0[l]) >> (pos_w - SHW'(CORDIC_MSB));
			end else begin
				xw = WW'(ax_s0[l]) << (SHW'(CORDIC_MSB) - pos_w);
				yw = WW'(ay_s0[l]) << (SHW'(CORDIC_MSB) - pos_w);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[l][0] <= signed'(xw[CORDIC_XW-1:0]);
				y_s[l][0] <= signed'(yw[CORDIC_XW-1:0]);
			end
		end

		for (genvar k = 0; k < ITER; k++) begin : g_iter
			localparam logic signed [ZACC_W-1:0] AT = ZACC_W'(atan_turn(k));
			logic signed [CORDIC_XW-1:0] xs, ys;
			logic signed [ZACC_W-1:0]    z_in;

			if (k == 0) begin : g_first
				assign z_in = '0;
			end else begin : g_next
				assign z_in = z_s[l][k];
			end

			assign xs = x_s[l][k] >>> k;
			assign ys = y_s[l][k] >>> k;

			always_ff @(posedge clk) begin
				if (en) begin
					if (!y_s[l][k][CORDIC_XW-1]) begin
						x_s[l][k+1] <= x_s[l][k] + ys;
						y_s[l][k+1] <= y_s[l][k] - xs;
						z_s[l][k+1] <= z_in + AT;
					end else begin
						x_s[l][k+1] <= x_s[l][k] - ys;
						y_s[l][k+1] <= y_s[l][k] + xs;
						z_s[l][k+1] <= z_in - AT;
					end
				end
			end
		end

		always_comb begin
			zc = z_s[l][ITER];
			f  = flg_q[ITER+1][l];
			if (f.zy) begin
				th = '0;
			end else if (f.zx) begin
				th = TURN_QUARTER;
			end else if (zc[ZACC_W-1]) begin
				th = '0;
			end else if (zc > $signed({1'b0, TURN_QUARTER})) begin
				th = TURN_QUARTER;
			end else begin
				th = zc[ANGLE_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!f.yneg) begin
					ang_q[l] <= f.xneg ? (TURN_HALF - th) : th;
				end else begin
					ang_q[l] <= f.xneg ? (TURN_HALF + th) : (TURN_FULL - th);
				end
			end
		end

		assign out_angle[l] = ang_q[l];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= in_side;
			for (int j = 1; j < NST; j++) begin
				side_q[j] <= side_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_vld};
		end
	end

	assign out_vld  = vld_q[NST-1];
	assign out_side = side_q[NST-1];

endmodule

@@ hw/rtl/sps_back.sv @@
// Back end: squares, square roots, signed distance, CORDIC angles and the
// output register. Depends on sps_pkg, sps_sqrt and sps_cordic.
module sps_back import sps_pkg::*; #(
	parameter int CW   = COORD_WIDTH_DEF,
	parameter int FB   = FRAC_BITS_DEF,
	parameter int ITER = ANGLE_ITER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_vld,
	input  logic [3*CW+3:0]      q_data,
	output logic                 q_pop,
	input  logic signed [CW-1:0] radius,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FB:0]          param_s,
	output logic [FB:0]          param_t,
	output logic signed [CW-1:0] signed_distance,
	output logic                 at_centre
);
	localparam int DW    = CW + 1;
	localparam int SQW   = 2 * CW;
	localparam int ACCW  = SQW + 2;
	localparam int IN_W  = ACCW + 2 * SQRT_EXTRA;
	localparam int RW    = IN_W / 2;
	localparam int SIDEA = 3 * CW + 4;
	localparam int SIDEB = CW + 1;
	localparam int ZDW   = RW + 2;

	logic                 en, out_vld_q;
	logic signed [DW-1:0] qa, qu, qv;

	logic                 vld_s1, cen_s1;
	logic [2:0]           sgn_s1;
	logic [CW-1:0]        ma_s1, mu_s1, mv_s1;

	logic                 vld_s2, cen_s2;
	logic [2:0]           sgn_s2;
	logic [CW-1:0]        ma_s2, mu_s2, mv_s2;
	logic [SQW-1:0]       sa_s2, su_s2, sv_s2;

	logic [ACCW-1:0]      acc;
	logic [SQW:0]         pls;
	logic [1:0][IN_W-1:0] sq_in;

	logic                 sq_vld;
	logic [1:0][RW-1:0]   sq_root;
	logic [SIDEA-1:0]     sq_side;
	logic                 sq_cen;
	logic [2:0]           sq_sgn;
	logic [CW-1:0]        sq_ma, sq_mu, sq_mv;

	logic signed [ZDW-1:0] dz;
	logic signed [CW-1:0]  zsat;
	logic                  rpos;

	logic [1:0][RW-1:0]      cr_ax, cr_ay;
	logic                    cr_vld;
	logic [1:0][ANGLE_W-1:0] cr_ang;
	logic [SIDEB-1:0]        cr_side;
	logic [ANGLE_W:0]        s_full, t_full;

	// whole pipeline advances unless a finished result is held
	assign en    = !out_vld_q || !out_stall;
	assign q_pop = en && q_vld;

	assign qa = q_data[3*DW-1 -: DW];
	assign qu = q_data[2*DW-1 -: DW];
	assign qv = q_data[DW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			cen_s1 <= q_data[3*DW];
			sgn_s1 <= {qa[DW-1], qu[DW-1], qv[DW-1]};
			ma_s1  <= qa[DW-1] ? CW'(-qa) : CW'(qa);
			mu_s1  <= qu[DW-1] ? CW'(-qu) : CW'(qu);
			mv_s1  <= qv[DW-1] ? CW'(-qv) : CW'(qv);

			cen_s2 <= cen_s1;
			sgn_s2 <= sgn_s1;
			ma_s2  <= ma_s1;
			mu_s2  <= mu_s1;
			mv_s2  <= mv_s1;
			sa_s2  <= SQW'(ma_s1) * SQW'(ma_s1);
			su_s2  <= SQW'(mu_s1) * SQW'(mu_s1);
			sv_s2  <= SQW'(mv_s1) * SQW'(mv_s1);
		end
	end

	always_comb begin
		acc      = ACCW'(sa_s2) + ACCW'(su_s2) + ACCW'(sv_s2);
		pls      = (SQW+1)'(su_s2) + (SQW+1)'(sv_s2);
		sq_in[0] = IN_W'(acc);
		sq_in[1] = IN_W'({pls, {(2*SQRT_EXTRA){1'b0}}});
	end

	sps_sqrt #(
		.IN_W   (IN_W),
		.SIDE_W (SIDEA)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_val   (sq_in),
		.in_side  ({cen_s2, sgn_s2, ma_s2, mu_s2, mv_s2}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	assign {sq_cen, sq_sgn, sq_ma, sq_mu, sq_mv} = sq_side;

	always_comb begin
		rpos = !radius[CW-1] && (radius != '0);
		if (rpos) begin
			dz = $signed({2'b00, sq_root[0]}) - ZDW'(radius);
		end else begin
			dz = -$signed({2'b00, sq_root[0]}) - ZDW'(radius);
		end
		if (dz > $signed(ZDW'({1'b0, {(CW-1){1'b1}}}))) begin
			zsat = {1'b0, {(CW-1){1'b1}}};
		end else if (dz < -$signed(ZDW'({1'b1, {(CW-1){1'b0}}}))) begin
			zsat = {1'b1, {(CW-1){1'b0}}};
		end else begin
			zsat = dz[CW-1:0];
		end
		cr_ax[0] = RW'(sq_mu);
		cr_ay[0] = RW'(sq_mv);
		cr_ax[1] = RW'({sq_ma, {SQRT_EXTRA{1'b0}}});
		cr_ay[1] = sq_root[1];
	end

	sps_cordic #(
		.AW     (RW),
		.ITER   (ITER),
		.SIDE_W (SIDEB)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (sq_vld),
		.in_ax     (cr_ax),
		.in_ay     (cr_ay),
		.in_xneg   ({sq_sgn[2], sq_sgn[1]}),
		.in_yneg   ({1'b0, sq_sgn[0]}),
		.in_side   ({sq_cen, zsat}),
		.out_vld   (cr_vld),
		.out_angle (cr_ang),
		.out_side  (cr_side)
	);

	assign s_full = (ANGLE_W+1)'(cr_ang[0]) + ((ANGLE_W+1)'(1) << (31 - FB));
	assign t_full = (ANGLE_W+1)'(cr_ang[1]) + ((ANGLE_W+1)'(1) << (30 - FB));

	always_ff @(posedge clk) begin
		if (en) begin
			param_s         <= s_full[32-FB +: FB+1];
			param_t         <= t_full[31-FB +: FB+1];
			signed_distance <= cr_side[CW-1:0];
			at_centre       <= cr_side[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= q_vld;
			vld_s2    <= vld_s1;
			out_vld_q <= cr_vld;
		end
	end

	assign out_valid = out_vld_q;

endmodule

@@ hw/rtl/sphere_point_to_surface_param.sv @@
// One point per cycle sustained while out_stall is low. Depth is set by the
// square-root pipeline (one root bit per stage) and the unrolled CORDIC.
// A 4-entry queue separates the input side from the datapath.
// Reset: centre 0, radius 1.0, pole Z, queue and pipeline empty.
// Depends on sps_pkg, sps_front and sps_back.
module sphere_point_to_surface_param import sps_pkg::*; #(
	parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
	parameter int FRAC_BITS        = FRAC_BITS_DEF,
	parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [FRAC_BITS:0]            param_s,
	output logic [FRAC_BITS:0]            param_t,
	output logic signed [COORD_WIDTH-1:0] signed_distance,
	output logic                          at_centre
);
	localparam int CW = COORD_WIDTH;

	logic signed [CW-1:0] centre_x_q, centre_y_q, centre_z_q, radius_q;
	logic [POLE_W-1:0]    pole_q;
	logic                 q_vld, q_pop;
	logic [3*CW+3:0]      q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			centre_z_q <= '0;
			radius_q   <= CW'(1) << FRAC_BITS;
			pole_q     <= POLE_Z;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTRE_X: centre_x_q <= cfg_data;
				CFG_CENTRE_Y: centre_y_q <= cfg_data;
				CFG_CENTRE_Z: centre_z_q <= cfg_data;
				CFG_RADIUS:   radius_q   <= cfg_data;
				CFG_POLE:     pole_q     <= cfg_data[POLE_W-1:0];
				default: ;
			endcase
		end
	end

	sps_front #(
		.CW (CW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.centre_x (centre_x_q),
		.centre_y (centre_y_q),
		.centre_z (centre_z_q),
		.radius   (radius_q),
		.pole     (pole_q),
		.q_vld    (q_vld),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	sps_back #(
		.CW   (CW),
		.FB   (FRAC_BITS),
		.ITER (ANGLE_ITERATIONS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_vld           (q_vld),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.radius          (radius_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.param_s         (param_s),
		.param_t         (param_t),
		.signed_distance (signed_distance),
		.at_centre       (at_centre)
	);

endmodule
